FILE: design/swcg_pkg.sv
package swcg_pkg;

  // Field widths of the transactions and the configuration port.
  localparam int unsigned CmdW      = 2;
  localparam int unsigned RegIdxW   = 2;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned SampleW   = 17;
  localparam int unsigned RateW     = 18;
  localparam int unsigned GainW     = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = RateW;

  // Wave timing widths.
  localparam int unsigned FreqW     = 11;
  localparam int unsigned SpanW     = 12;
  localparam int unsigned PhaseW    = 12;
  localparam int unsigned ProdW     = RateW + SpanW;
  localparam int unsigned SpwShift  = 17;
  localparam int unsigned ThreshW   = PhaseW + 3;
  localparam int unsigned LenW      = 6;
  localparam int unsigned VolW      = 4;
  localparam int unsigned VolScaleW = 9;

  localparam logic [SpanW-1:0]     FreqSpan    = 12'd2048;
  localparam logic [LenW-1:0]      LenReload   = 6'd63;
  localparam logic [VolScaleW-1:0] VolStep     = 9'd34;

  // Reset values of the configuration registers.
  localparam logic [RateW-1:0] RateReset = 18'd44100;
  localparam logic [GainW-1:0] GainReset = 8'd1;

  // Transaction kinds.
  typedef enum logic [CmdW-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_LENGTH = 2'd1,
    CMD_SAMPLE = 2'd2
  } cmd_e;

  // Channel register targets.
  typedef enum logic [RegIdxW-1:0] {
    REG_DUTY_LEN = 2'd0,
    REG_VOLUME   = 2'd1,
    REG_FREQ_LO  = 2'd2,
    REG_FREQ_HI  = 2'd3
  } reg_idx_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAMPLE_RATE   = 2'd0,
    CFG_MASTER_ENABLE = 2'd1,
    CFG_MASTER_GAIN   = 2'd2
  } cfg_idx_e;

  // Scales one wave length by the duty numerator 1, 2, 4 or 6, using shifts and one addition.
  function automatic logic [ThreshW-1:0] duty_scale(input logic [1:0] sel,
                                                    input logic [PhaseW-1:0] spw);
    logic [ThreshW-1:0] x;
    logic [ThreshW-1:0] res;
    x = ThreshW'(spw);
    case (sel)
      2'd0:    res = x;
      2'd1:    res = x << 1;
      2'd2:    res = x << 2;
      default: res = (x << 2) + (x << 1);
    endcase
    return res;
  endfunction

endpackage

FILE: design/swcg_in_if.sv
interface swcg_in_if
  import swcg_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CmdW-1:0]    cmd;
  logic [RegIdxW-1:0] reg_index;
  logic [ByteW-1:0]   write_data;

  modport source (output valid, output cmd, output reg_index, output write_data,
                  input ready);
  modport sink (input valid, input cmd, input reg_index, input write_data,
                output ready);
endinterface

FILE: design/swcg_out_if.sv
interface swcg_out_if
  import swcg_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample_value;
  logic               channel_active;

  modport source (output valid, output sample_value, output channel_active,
                  input ready);
  modport sink (input valid, input sample_value, input channel_active,
                output ready);
endinterface

FILE: design/square_wave_channel_generator.sv
// Channel   Direction  Carries
// in_i      sink       cmd, reg_index, write_data
// out_o     source     sample_value, channel_active
// cfg_*     write only sample_rate, master_enable, master_gain
//
// One transaction is accepted every cycle while out_o does not stall; its result moves from
// the input to the output register; the combinational state update sets the rate.
// Reset clears the channel registers and loads the configuration defaults.
// A stalled result holds the output register, and the input register then holds too.
module square_wave_channel_generator
  import swcg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  swcg_in_if.sink             in_i,
  swcg_out_if.source          out_o
);

  // Configuration registers.
  logic [RateW-1:0] rate_q;
  logic             master_en_q;
  logic [GainW-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= RateReset;
      master_en_q <= 1'b1;
      gain_q      <= GainReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SAMPLE_RATE:   rate_q      <= cfg_data_i[RateW-1:0];
        CFG_MASTER_ENABLE: master_en_q <= cfg_data_i[0];
        CFG_MASTER_GAIN:   gain_q      <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: the input register advances when the output register is free.
  logic               in_valid_q;
  logic [CmdW-1:0]    cmd_q;
  logic [RegIdxW-1:0] idx_q;
  logic [ByteW-1:0]   data_q;
  logic               out_valid_q;
  logic               advance;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q  <= in_i.cmd;
      idx_q  <= in_i.reg_index;
      data_q <= in_i.write_data;
    end
  end

  // Channel state.
  logic [ByteW-1:0]  duty_len_q, duty_len_d;
  logic [ByteW-1:0]  volume_q, volume_d;
  logic [ByteW-1:0]  freq_lo_q, freq_lo_d;
  logic [6:0]        freq_hi_q, freq_hi_d;
  logic              chan_on_q, chan_on_d;
  logic [PhaseW-1:0] phase_q, phase_d;

  // Wave length in samples from the sample rate and the frequency code.
  logic [FreqW-1:0]   freq;
  logic [SpanW-1:0]   span;
  logic [ProdW-1:0]   prod;
  logic [PhaseW-1:0]  spw;
  logic [PhaseW-1:0]  ph_use;
  logic [PhaseW-1:0]  ph_inc;
  logic [ThreshW-1:0] thresh;
  logic               wave_low;
  logic               tone_on;
  logic [VolScaleW-1:0] vol_scaled;
  logic [SampleW-1:0] level;
  logic [LenW-1:0]    len_dec;
  logic [SampleW-1:0] sample_d;

  assign freq   = {freq_hi_q[2:0], freq_lo_q};
  assign span   = FreqSpan - SpanW'(freq);
  assign prod   = ProdW'(rate_q) * ProdW'(span);
  assign spw    = prod[SpwShift+PhaseW-1:SpwShift];
  assign ph_use = (phase_q >= spw) ? '0 : phase_q;
  assign ph_inc = ph_use + 1'b1;
  assign thresh = duty_scale(duty_len_q[7:6], spw);
  assign wave_low = {ph_use, 3'b000} > thresh;
  assign tone_on  = chan_on_q && master_en_q && (spw != '0);

  // Amplitude of the high part of the wave.
  assign vol_scaled = VolScaleW'(volume_q[7:4]) * VolStep;
  assign level      = SampleW'(vol_scaled) * SampleW'(gain_q);

  assign len_dec = duty_len_q[LenW-1:0] - 1'b1;

  // Next channel state and result for the transaction in the input register.
  always_comb begin
    duty_len_d = duty_len_q;
    volume_d   = volume_q;
    freq_lo_d  = freq_lo_q;
    freq_hi_d  = freq_hi_q;
    chan_on_d  = chan_on_q;
    phase_d    = phase_q;
    sample_d   = '0;
    unique case (cmd_q)
      CMD_WRITE: begin
        unique case (idx_q)
          REG_DUTY_LEN: duty_len_d = data_q;
          REG_VOLUME:   volume_d   = data_q;
          REG_FREQ_LO:  freq_lo_d  = data_q;
          default: begin
            freq_hi_d = data_q[6:0];
            if (data_q[7]) begin
              chan_on_d = 1'b1;
              phase_d   = '0;
              if (duty_len_q[LenW-1:0] == '0) begin
                duty_len_d = {duty_len_q[7:6], LenReload};
              end
            end
          end
        endcase
      end
      CMD_LENGTH: begin
        if (chan_on_q && freq_hi_q[6]) begin
          duty_len_d = {duty_len_q[7:6], len_dec};
          if (len_dec == '0) begin
            chan_on_d = 1'b0;
          end
        end
      end
      CMD_SAMPLE: begin
        if (tone_on) begin
          sample_d = wave_low ? '0 : level;
          phase_d  = (ph_inc == spw) ? '0 : ph_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_len_q <= '0;
      volume_q   <= '0;
      freq_lo_q  <= '0;
      freq_hi_q  <= '0;
      chan_on_q  <= 1'b0;
      phase_q    <= '0;
    end else if (advance) begin
      duty_len_q <= duty_len_d;
      volume_q   <= volume_d;
      freq_lo_q  <= freq_lo_d;
      freq_hi_q  <= freq_hi_d;
      chan_on_q  <= chan_on_d;
      phase_q    <= phase_d;
    end
  end

  // Result register.
  logic [SampleW-1:0] sample_q;
  logic               active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sample_q <= sample_d;
      active_q <= chan_on_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.sample_value   = sample_q;
  assign out_o.channel_active = active_q;

  // The reported status matches the channel state left by the same transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_o.channel_active == chan_on_q))
    else $error("channel status does not match channel state");

  // The phase moves only when a transaction is processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(phase_q))
    else $error("phase changed without a transaction");

  // Only a sample tick can give a nonzero sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (cmd_q != CMD_SAMPLE)) |=> (out_o.sample_value == '0))
    else $error("nonzero sample from a non-sample transaction");

  // A disabled channel is silent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !chan_on_q) |=> (out_o.sample_value == '0))
    else $error("nonzero sample while the channel is off");

endmodule
